// File: sv/battery_soc_display_smoother_assert.svh
// Assertion macros shared by the display smoother RTL.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef BATTERY_SOC_DISPLAY_SMOOTHER_ASSERT_SVH
`define BATTERY_SOC_DISPLAY_SMOOTHER_ASSERT_SVH

`ifndef SYNTH
`define BSDS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define BSDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BSDS_ASSERT_ALWAYS(lbl, expr, msg)
`define BSDS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/bsds_pkg.sv
// Shared types and constants for the battery SOC display smoother.
// No dependencies; used by bsds_step and the top level.
package bsds_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OPPOSE_DIST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONF_SHORT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CONF_LONG   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_MIN    = 3'd6;

	localparam logic [1:0] DIR_IDLE = 2'b00;
	localparam logic [1:0] DIR_CHG  = 2'b01;
	localparam logic [1:0] DIR_DIS  = 2'b11;

	localparam logic [6:0] SOC_MAX = 7'd100;
	localparam logic [7:0] CNT_MAX = 8'd255;

	typedef struct packed {
		logic       take;
		logic       up;
		logic [7:0] cnt;
	} step_ctl_t;

endpackage

// File: sv/battery_soc_display_smoother.sv
// Top level of the battery SOC display smoother: input register, state, result register.
// Uses bsds_pkg, bsds_filter, bsds_step and the assertion header.
//
// One sample in, one result out, at one sample per clock while the output is not stalled. A
// transfer on the input lands in the input register; from there the filter multiply, target
// rounding and step decision run against the stored state and the result is written to the
// output register. The input keeps taking transfers while a result waits, as long as the input
// register can move on; it stalls only when both registers are full and the output is stalled.
// The first sample after reset loads the display and filter directly. Configuration is written
// through the cfg port; the user must do so only while the block is idle, which it does not enforce.
module battery_soc_display_smoother #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [bsds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bsds_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          soc_raw,
	input  logic signed [15:0]                  battery_current_ma,
	input  logic [31:0]                         time_ms,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [6:0]                          soc_shown,
	output logic [FRAC_BITS+6:0]                soc_filtered_q16,
	output logic signed [1:0]                   flow_direction
);
	import bsds_pkg::*;

	localparam int unsigned FW = FRAC_BITS + 7;

	logic [15:0] alpha_q;
	logic [14:0] thr_q;
	logic [31:0] min_step_q;
	logic [35:0] min_step_x10_q;
	logic [6:0]  oppose_dist_q;
	logic [7:0]  conf_short_q;
	logic [7:0]  conf_long_q;
	logic [6:0]  idle_min_q;

	logic               valid_s1;
	logic [7:0]         soc_s1;
	logic signed [15:0] cur_s1;
	logic [31:0]        time_s1;

	logic          started_q;
	logic [FW-1:0] filt_q;
	logic [6:0]    disp_q;
	logic [31:0]   last_step_q;
	logic [7:0]    cnt_q;
	logic [1:0]    prev_dir_q;

	logic          in_xfer;
	logic          advance;
	logic [6:0]    soc_sat;
	logic [1:0]    dir;
	logic [FW-1:0] filt_next;
	logic [6:0]    target;
	logic [31:0]   elapsed;
	logic [6:0]    disp_next;
	step_ctl_t     ctl;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q        <= 16'd9830;
			thr_q          <= 15'd50;
			min_step_q     <= 32'd60000;
			min_step_x10_q <= 36'd600000;
			oppose_dist_q  <= 7'd5;
			conf_short_q   <= 8'd6;
			conf_long_q    <= 8'd60;
			idle_min_q     <= 7'd2;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ALPHA:      alpha_q <= cfg_data[15:0];
				REG_THRESHOLD:  thr_q   <= cfg_data[14:0];
				REG_MIN_STEP: begin
					min_step_q     <= cfg_data;
					min_step_x10_q <= {1'b0, cfg_data, 3'b0} + {3'b0, cfg_data, 1'b0};
				end
				REG_OPPOSE_DIST: oppose_dist_q <= cfg_data[6:0];
				REG_CONF_SHORT:  conf_short_q  <= cfg_data[7:0];
				REG_CONF_LONG:   conf_long_q   <= cfg_data[7:0];
				REG_IDLE_MIN:    idle_min_q    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			soc_s1  <= soc_raw;
			cur_s1  <= battery_current_ma;
			time_s1 <= time_ms;
		end
	end

	// per-sample logic
	assign soc_sat = (soc_s1 > {1'b0, SOC_MAX}) ? SOC_MAX : soc_s1[6:0];

	always_comb begin
		if ($signed({cur_s1[15], cur_s1}) > $signed({2'b0, thr_q}))
			dir = DIR_CHG;
		else if ($signed({cur_s1[15], cur_s1}) < -$signed({2'b0, thr_q}))
			dir = DIR_DIS;
		else
			dir = DIR_IDLE;
	end

	assign elapsed = time_s1 - last_step_q;

	bsds_filter #(
		.FRAC_BITS(FRAC_BITS)
	) u_filter (
		.soc_sat   (soc_sat),
		.filt      (filt_q),
		.alpha     (alpha_q),
		.filt_next (filt_next),
		.target    (target)
	);

	bsds_step u_step (
		.dir          (dir),
		.prev_dir     (prev_dir_q),
		.target       (target),
		.display      (disp_q),
		.cnt          (cnt_q),
		.elapsed      (elapsed),
		.min_step     (min_step_q),
		.min_step_x10 (min_step_x10_q),
		.oppose_dist  (oppose_dist_q),
		.conf_short   (conf_short_q),
		.conf_long    (conf_long_q),
		.idle_min     (idle_min_q),
		.ctl          (ctl)
	);

	always_comb begin
		disp_next = disp_q;
		if (ctl.take) begin
			if (ctl.up && disp_q < SOC_MAX)
				disp_next = disp_q + 7'd1;
			else if (!ctl.up && disp_q != 7'd0)
				disp_next = disp_q - 7'd1;
		end
	end

	// state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			filt_q      <= '0;
			disp_q      <= '0;
			last_step_q <= '0;
			cnt_q       <= '0;
			prev_dir_q  <= DIR_IDLE;
		end else if (advance) begin
			if (!started_q) begin
				started_q   <= 1'b1;
				disp_q      <= soc_sat;
				filt_q      <= {soc_sat, {FRAC_BITS{1'b0}}};
				last_step_q <= time_s1;
				cnt_q       <= 8'd0;
				prev_dir_q  <= DIR_IDLE;
			end else begin
				filt_q     <= filt_next;
				disp_q     <= disp_next;
				cnt_q      <= ctl.cnt;
				prev_dir_q <= dir;
				if (ctl.take)
					last_step_q <= time_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			soc_shown        <= started_q ? disp_next : soc_sat;
			soc_filtered_q16 <= started_q ? filt_next : {soc_sat, {FRAC_BITS{1'b0}}};
			flow_direction   <= dir;
		end
	end

`include "battery_soc_display_smoother_assert.svh"

	`BSDS_ASSERT_ALWAYS(a_disp_range, disp_q <= SOC_MAX, "display above 100")
	`BSDS_ASSERT_ALWAYS(a_filt_range, filt_q <= (FW'(100) << FRAC_BITS), "filter above 100")
	`BSDS_ASSERT_NEXT(a_state_hold, !advance, $stable(disp_q) && $stable(filt_q), "state moved with no sample")
	`BSDS_ASSERT_NEXT(a_out_follows, advance, out_valid, "result lost after advance")

endmodule

// File: sv/bsds_filter.sv
// Exponential average of the saturated percent and rounded target.
// Pure combinational; width follows FRAC_BITS. No package use.
module bsds_filter #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic [6:0]             soc_sat,
	input  logic [FRAC_BITS+6:0]   filt,
	input  logic [15:0]            alpha,
	output logic [FRAC_BITS+6:0]   filt_next,
	output logic [6:0]             target
);
	localparam int unsigned FW = FRAC_BITS + 7;
	localparam int unsigned DW = FW + 1;
	localparam int unsigned PW = DW + 17;
	localparam int unsigned QW = PW - 16;
	localparam int unsigned SW = QW + 1;
	localparam logic [FW-1:0] FILT_MAX = FW'(100) << FRAC_BITS;
	localparam logic [FW-1:0] HALF     = FW'(1) << (FRAC_BITS - 1);

	logic signed [DW-1:0] d;
	logic signed [PW-1:0] p;
	logic signed [PW-1:0] pr;
	logic signed [QW-1:0] q;
	logic signed [SW-1:0] sum;
	logic        [FW-1:0] tsum;

	assign d   = $signed({1'b0, soc_sat, {FRAC_BITS{1'b0}}}) - $signed({1'b0, filt});
	assign p   = $signed({{(PW-17){1'b0}}, 1'b0, alpha}) * $signed({{(PW-DW){d[DW-1]}}, d});
	// round to nearest, ties toward +inf
	assign pr  = p + $signed(PW'(32768));
	assign q   = pr[PW-1:16];
	assign sum = $signed({q[QW-1], q}) + $signed({{(SW-FW){1'b0}}, filt});

	always_comb begin
		if (sum[SW-1])
			filt_next = '0;
		else if (sum > $signed({{(SW-FW){1'b0}}, FILT_MAX}))
			filt_next = FILT_MAX;
		else
			filt_next = sum[FW-1:0];
	end

	assign tsum   = filt_next + HALF;
	assign target = tsum[FW-1:FRAC_BITS];
endmodule

// File: sv/bsds_step.sv
// Step decision: confirm counter and one-percent display step control.
// Pure combinational; uses bsds_pkg for direction codes and step_ctl_t.
module bsds_step (
	input  logic [1:0]              dir,
	input  logic [1:0]              prev_dir,
	input  logic [6:0]              target,
	input  logic [6:0]              display,
	input  logic [7:0]              cnt,
	input  logic [31:0]             elapsed,
	input  logic [31:0]             min_step,
	input  logic [35:0]             min_step_x10,
	input  logic [6:0]              oppose_dist,
	input  logic [7:0]              conf_short,
	input  logic [7:0]              conf_long,
	input  logic [6:0]              idle_min,
	output bsds_pkg::step_ctl_t     ctl
);
	import bsds_pkg::*;

	logic signed [7:0] diff;
	logic        [6:0] adiff;
	logic        [7:0] cnt_base;
	logic        [7:0] bump;
	logic              ok_el;
	logic              ok_el10;

	assign diff     = $signed({1'b0, target}) - $signed({1'b0, display});
	assign adiff    = diff[7] ? 7'(-diff) : diff[6:0];
	assign cnt_base = (dir != prev_dir) ? 8'd0 : cnt;
	assign bump     = (cnt_base == CNT_MAX) ? CNT_MAX : cnt_base + 8'd1;
	assign ok_el    = elapsed >= min_step;
	assign ok_el10  = {4'b0, elapsed} >= min_step_x10;

	always_comb begin
		ctl.take = 1'b0;
		ctl.up   = 1'b0;
		ctl.cnt  = 8'd0;
		if (diff == 8'sd0) begin
			ctl.cnt = 8'd0;
		end else if (dir == DIR_CHG) begin
			if (!diff[7]) begin
				ctl.cnt  = cnt_base;
				ctl.take = ok_el;
				ctl.up   = 1'b1;
			end else if (adiff >= oppose_dist) begin
				ctl.cnt = bump;
				if (bump >= conf_short && ok_el) begin
					ctl.take = 1'b1;
					ctl.cnt  = 8'd0;
				end
			end
		end else if (dir == DIR_DIS) begin
			if (diff[7]) begin
				ctl.cnt  = cnt_base;
				ctl.take = ok_el;
			end else if (adiff >= oppose_dist) begin
				ctl.cnt = bump;
				ctl.up  = 1'b1;
				if (bump >= conf_long && ok_el10) begin
					ctl.take = 1'b1;
					ctl.cnt  = 8'd0;
				end
			end
		end else begin
			if (adiff >= idle_min) begin
				ctl.cnt = bump;
				ctl.up  = !diff[7];
				if (bump >= conf_short && ok_el) begin
					ctl.take = 1'b1;
					ctl.cnt  = 8'd0;
				end
			end
		end
	end
endmodule
